### src/tsw_pkg.sv
// Package for the thinning sub-pass window block.
// Holds shared types, register indexes and reset constants; no dependencies.
`default_nettype none

package tsw_pkg;

   localparam int MAX_WIDTH_DEF = 2048;

   localparam int IMG_W_BITS = 12;
   localparam int IMG_H_BITS = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SUB_PASS     = 2'd2;

   localparam logic [IMG_W_BITS-1:0] IMAGE_WIDTH_RST  = 12'd2048;
   localparam logic [IMG_H_BITS-1:0] IMAGE_HEIGHT_RST = 16'd2048;

   // Position flags of one pixel, worked out when it is taken in
   typedef struct packed {
      logic emit_a;   // emits the pixel one row up, one column left
      logic judge;    // that pixel is interior, so it may be cleared
      logic emit_b;   // last column: also emits the pixel straight above
      logic done;     // current row is the last one of the frame
   } pos_flags_type;

   typedef struct packed {
      logic pixel_out;
      logic row_end;
      logic frame_done;
      logic last_of_run;
   } result_type;

endpackage

`default_nettype wire

### src/tsw_req_if.sv
// Input channel of the thinning window: valid/ready plus one pixel item.
// No dependencies.
`default_nettype none

interface tsw_req_if;
   logic valid;
   logic ready;
   logic pixel_in;
   logic frame_start;

   modport source (output valid, output pixel_in, output frame_start, input ready);
   modport sink (input valid, input pixel_in, input frame_start, output ready);
endinterface

`default_nettype wire

### src/tsw_rsp_if.sv
// Result channel of the thinning window: valid/ready plus one result item.
// No dependencies.
`default_nettype none

interface tsw_rsp_if;
   logic valid;
   logic ready;
   logic pixel_out;
   logic row_end;
   logic frame_done;
   logic last_of_run;

   modport source (output valid, output pixel_out, output row_end, output frame_done,
                   output last_of_run, input ready);
   modport sink (input valid, input pixel_out, input row_end, input frame_done,
                 input last_of_run, output ready);
endinterface

`default_nettype wire

### src/tsw_line_buffer.sv
// Two one-bit row stores (row r-2 and row r-1) with registered read.
// A read at the address written in the same cycle returns the new data.
`default_nettype none

module tsw_line_buffer
   import tsw_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   localparam int COL_W = $clog2(MAX_WIDTH)
) (
   input  wire logic             clock,
   input  wire logic             rd_en,
   input  wire logic [COL_W-1:0] rd_addr,
   input  wire logic             wr_en,
   input  wire logic [COL_W-1:0] wr_addr,
   input  wire logic             wr_older,
   input  wire logic             wr_prev,
   output logic                  up_bit,
   output logic                  mid_bit
);

   logic older_mem [MAX_WIDTH];
   logic prev_mem  [MAX_WIDTH];
   logic up_ff;
   logic mid_ff;
   logic bypass;

   assign bypass = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         older_mem[wr_addr] <= wr_older;
         prev_mem[wr_addr]  <= wr_prev;
      end
      if (rd_en) begin
         up_ff  <= bypass ? wr_older : older_mem[rd_addr];
         mid_ff <= bypass ? wr_prev : prev_mem[rd_addr];
      end
   end

   assign up_bit  = up_ff;
   assign mid_bit = mid_ff;

endmodule

`default_nettype wire

### src/tsw_decide.sv
// 3x3 window register and the skeleton-thinning clear decision for its center.
// Uses tsw_pkg for the position flags and result types.
`default_nettype none

module tsw_decide
   import tsw_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire logic          up_bit,
   input  wire logic          mid_bit,
   input  wire logic          pix_bit,
   input  wire pos_flags_type flags,
   input  wire logic          sub_pass,
   output result_type         res_a,
   output logic               res_a_valid,
   output result_type         res_b,
   output logic               res_b_valid
);

   logic [8:0] window_ff;
   logic [8:0] window_in;
   logic p2, p3, p4, p5, p6, p7, p8, p9;
   logic [2:0] cross_cnt;
   logic [2:0] n1;
   logic [2:0] n2;
   logic [2:0] n_min;
   logic corner;
   logic clear_ctr;

   // Oldest column in the low bits, top row first within a column
   assign window_in = {pix_bit, mid_bit, up_bit, window_ff[8:3]};

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (advance) begin
         window_ff <= window_in;
      end
   end

   always_comb begin
      p2 = window_in[3];
      p3 = window_in[6];
      p4 = window_in[7];
      p5 = window_in[8];
      p6 = window_in[5];
      p7 = window_in[2];
      p8 = window_in[1];
      p9 = window_in[0];

      cross_cnt = 3'(!p2 && (p3 || p4)) + 3'(!p4 && (p5 || p6))
                + 3'(!p6 && (p7 || p8)) + 3'(!p8 && (p9 || p2));
      n1 = 3'(p9 || p2) + 3'(p3 || p4) + 3'(p5 || p6) + 3'(p7 || p8);
      n2 = 3'(p2 || p3) + 3'(p4 || p5) + 3'(p6 || p7) + 3'(p8 || p9);
      n_min = (n1 < n2) ? n1 : n2;
      corner = sub_pass ? ((p2 || p3 || !p5) && p4) : ((p6 || p7 || !p9) && p8);
      clear_ctr = (cross_cnt == 3'd1) && (n_min >= 3'd2) && (n_min <= 3'd3) && !corner;

      res_a.pixel_out   = window_in[4] && !(flags.judge && clear_ctr);
      res_a.row_end     = 1'b0;
      res_a.frame_done  = 1'b0;
      res_a.last_of_run = !flags.emit_b;
      res_a_valid       = flags.emit_a;

      res_b.pixel_out   = mid_bit;
      res_b.row_end     = 1'b1;
      res_b.frame_done  = flags.done;
      res_b.last_of_run = 1'b1;
      res_b_valid       = flags.emit_b;
   end

endmodule

`default_nettype wire

### src/tsw_out_queue.sv
// Two-entry result register: holds the results of one item until taken.
// Uses tsw_pkg for the result type.
`default_nettype none

module tsw_out_queue
   import tsw_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire result_type res_a,
   input  wire logic       res_a_valid,
   input  wire result_type res_b,
   input  wire logic       res_b_valid,
   output logic            can_load,
   output logic            out_valid,
   output result_type      out_data,
   input  wire logic       out_ready
);

   result_type head_ff, head_in;
   result_type tail_ff, tail_in;
   logic head_v_ff, head_v_in;
   logic tail_v_ff, tail_v_in;
   logic pop;

   assign pop      = head_v_ff && out_ready;
   assign can_load = !head_v_ff || (pop && !tail_v_ff);

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      head_v_in = head_v_ff;
      tail_v_in = tail_v_ff;
      if (load) begin
         if (res_a_valid) begin
            head_in   = res_a;
            head_v_in = 1'b1;
            tail_in   = res_b;
            tail_v_in = res_b_valid;
         end else begin
            head_in   = res_b;
            head_v_in = res_b_valid;
            tail_v_in = 1'b0;
         end
      end else if (pop) begin
         // advance the second result to the front
         head_in   = tail_ff;
         head_v_in = tail_v_ff;
         tail_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff <= 1'b0;
         tail_v_ff <= 1'b0;
      end else begin
         head_v_ff <= head_v_in;
         tail_v_ff <= tail_v_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign out_valid = head_v_ff;
   assign out_data  = head_ff;

endmodule

`default_nettype wire

### src/thinning_subpass_window.sv
// Thinning sub-pass window: one skeleton-thinning sub-pass over a raster pixel stream.
// Throughput: one pixel per clock while the result channel is ready; a last-column
// pixel gives two results, and the second holds the output register and stalls input.
// Reset clears position counters, window, valid flags and loads register
// defaults; the row stores are not cleared and hold junk until written.
`default_nettype none

module thinning_subpass_window
   import tsw_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   tsw_req_if.sink                    req_ch,
   tsw_rsp_if.source                  rsp_ch,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WU_BITS = $clog2(MAX_WIDTH + 1);
   localparam int EXT_W = (WU_BITS > IMG_W_BITS) ? WU_BITS : IMG_W_BITS;

   logic [IMG_W_BITS-1:0] image_width_ff;
   logic [IMG_H_BITS-1:0] image_height_ff;
   logic                  sub_pass_ff;

   logic [EXT_W-1:0]      width_ext;
   logic [EXT_W-1:0]      width_use;
   logic [COL_W-1:0]      col_last;
   logic [IMG_H_BITS-1:0] row_last;

   logic [COL_W-1:0]      col_ff, col_in;
   logic [IMG_H_BITS-1:0] row_ff, row_in;
   logic [COL_W-1:0]      col_base, col_cur;
   logic [IMG_H_BITS-1:0] row_base, row_cur;
   pos_flags_type         flags_cur;

   logic                  s1_v_ff, s1_v_in;
   logic                  s1_pix_ff;
   logic [COL_W-1:0]      s1_col_ff;
   pos_flags_type         s1_flags_ff;

   logic                  accept;
   logic                  s1_adv;
   logic                  can_load;
   logic                  up_bit, mid_bit;
   result_type            res_a, res_b, out_data;
   logic                  res_a_valid, res_b_valid;

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RST;
         image_height_ff <= IMAGE_HEIGHT_RST;
         sub_pass_ff     <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[IMG_W_BITS-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[IMG_H_BITS-1:0];
            CSR_SUB_PASS:     sub_pass_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Bounds in use: width saturated to 3..MAX_WIDTH, height to at least 3
   always_comb begin
      width_ext = EXT_W'(image_width_ff);
      if (width_ext < EXT_W'(3)) begin
         width_use = EXT_W'(3);
      end else if (width_ext > EXT_W'(MAX_WIDTH)) begin
         width_use = EXT_W'(MAX_WIDTH);
      end else begin
         width_use = width_ext;
      end
      col_last = COL_W'(width_use - EXT_W'(1));
      row_last = (image_height_ff < IMG_H_BITS'(3)) ? IMG_H_BITS'(2)
                                                    : image_height_ff - IMG_H_BITS'(1);
   end

   assign s1_adv       = s1_v_ff && can_load;
   assign req_ch.ready = !s1_v_ff || s1_adv;
   assign accept       = req_ch.valid && req_ch.ready;

   // Position of the incoming pixel and of the next one
   always_comb begin
      col_base = req_ch.frame_start ? '0 : col_ff;
      row_base = req_ch.frame_start ? '0 : row_ff;
      col_cur  = (col_base > col_last) ? col_last : col_base;
      row_cur  = (row_base > row_last) ? row_last : row_base;

      flags_cur.emit_a = (row_cur != '0) && (col_cur != '0);
      flags_cur.judge  = (row_cur >= IMG_H_BITS'(2)) && (col_cur >= COL_W'(2));
      flags_cur.emit_b = (row_cur != '0) && (col_cur == col_last);
      flags_cur.done   = (row_cur == row_last);

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_cur == col_last) begin
            col_in = '0;
            row_in = (row_cur == row_last) ? '0 : row_cur + IMG_H_BITS'(1);
         end else begin
            col_in = col_cur + COL_W'(1);
            row_in = row_cur;
         end
      end

      s1_v_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         s1_v_ff <= 1'b0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         s1_v_ff <= s1_v_in;
      end
      if (accept) begin
         s1_pix_ff   <= req_ch.pixel_in;
         s1_col_ff   <= col_cur;
         s1_flags_ff <= flags_cur;
      end
   end

   // Row stores are read on accept and rewritten as the item leaves stage one
   tsw_line_buffer #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buffer (
      .clock    (clock),
      .rd_en    (accept),
      .rd_addr  (col_cur),
      .wr_en    (s1_adv),
      .wr_addr  (s1_col_ff),
      .wr_older (mid_bit),
      .wr_prev  (s1_pix_ff),
      .up_bit   (up_bit),
      .mid_bit  (mid_bit)
   );

   tsw_decide u_decide (
      .clock       (clock),
      .reset       (reset),
      .advance     (s1_adv),
      .up_bit      (up_bit),
      .mid_bit     (mid_bit),
      .pix_bit     (s1_pix_ff),
      .flags       (s1_flags_ff),
      .sub_pass    (sub_pass_ff),
      .res_a       (res_a),
      .res_a_valid (res_a_valid),
      .res_b       (res_b),
      .res_b_valid (res_b_valid)
   );

   tsw_out_queue u_out_queue (
      .clock       (clock),
      .reset       (reset),
      .load        (s1_adv),
      .res_a       (res_a),
      .res_a_valid (res_a_valid),
      .res_b       (res_b),
      .res_b_valid (res_b_valid),
      .can_load    (can_load),
      .out_valid   (rsp_ch.valid),
      .out_data    (out_data),
      .out_ready   (rsp_ch.ready)
   );

   assign rsp_ch.pixel_out   = out_data.pixel_out;
   assign rsp_ch.row_end     = out_data.row_end;
   assign rsp_ch.frame_done  = out_data.frame_done;
   assign rsp_ch.last_of_run = out_data.last_of_run;

endmodule

`default_nettype wire
